// ----- hw/rtl/hsli_pkg.sv -----
// shared types and constants of the half-sample line interpolator
package hsli_pkg;

	localparam int TAPS = 6;

	localparam logic [1:0] MODE_BILINEAR = 2'd0;
	localparam logic [1:0] MODE_BICUBIC  = 2'd1;
	localparam logic [1:0] MODE_WIENER   = 2'd2;
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	localparam logic REG_FILTER_MODE = 1'b0;
	localparam logic REG_SAMPLE_BITS = 1'b1;

	localparam logic [1:0] FILTER_MODE_RST = MODE_WIENER;
	localparam logic [4:0] SAMPLE_BITS_RST = 5'd8;
	localparam logic [4:0] MIN_SAMPLE_BITS = 5'd8;

	localparam logic [3:0] POS_SAT      = 4'd8;
	localparam logic [3:0] LAG          = 4'd3;
	localparam logic [3:0] WIENER_MIN_N = 4'd5;
	localparam logic [3:0] BICUBIC_MIN_N = 4'd4;

	localparam int WIENER_ROUND  = 16;
	localparam int BICUBIC_ROUND = 8;
	localparam int WIENER_SHIFT  = 5;
	localparam int BICUBIC_SHIFT = 4;

	typedef enum logic [1:0] {
		K_WIENER,
		K_BICUBIC,
		K_AVG,
		K_COPY
	} kern_t;

	// per-result control handed from the sequencer to the kernel
	typedef struct packed {
		kern_t      kern;
		logic [1:0] dsel;
		logic       done;
	} sel_t;

endpackage

// ----- hw/rtl/hsli_tap_cell.sv -----
// one cell of the sample window: holds a sample and passes it on on each request
module hsli_tap_cell #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    shift_en,
	input  logic [SAMPLE_WIDTH-1:0] d,
	output logic [SAMPLE_WIDTH-1:0] q
);
	logic [SAMPLE_WIDTH-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;
endmodule

// ----- hw/rtl/hsli_kernel.sv -----
// filter sums over the window cells, registered before the clamp
module hsli_kernel #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    en,
	input  logic [hsli_pkg::TAPS-1:0][SAMPLE_WIDTH-1:0] taps,
	input  hsli_pkg::sel_t                          ctl,
	output logic signed [SAMPLE_WIDTH+6:0]          acc_s2,
	output hsli_pkg::sel_t                          ctl_s2
);
	import hsli_pkg::*;

	localparam int AW = SAMPLE_WIDTH + 7;

	logic signed [AW-1:0] x [TAPS];
	logic signed [AW-1:0] inner_w;
	logic signed [AW-1:0] outer_w;
	logic signed [AW-1:0] inner_b;
	logic signed [AW-1:0] outer_b;
	logic signed [AW-1:0] pair_a;
	logic signed [AW-1:0] sum;

	always_comb begin
		for (int i = 0; i < TAPS; i++) begin
			x[i] = $signed(AW'(taps[i]));
		end
	end

	// x[k] is sample n-k of the line
	assign inner_w = x[3] + x[2];
	assign outer_w = x[4] + x[1];
	assign inner_b = x[3] + x[2];
	assign outer_b = x[4] + x[1];

	always_comb begin
		case (ctl.dsel)
			2'd1:    pair_a = x[1] + x[0];
			2'd2:    pair_a = x[2] + x[1];
			default: pair_a = x[3] + x[2];
		endcase
	end

	always_comb begin
		case (ctl.kern)
			K_WIENER: begin
				// 20*(c+d) - 5*(b+e) + (a+f)
				sum = (x[5] + x[0]) + ((inner_w <<< 4) + (inner_w <<< 2))
					- ((outer_w <<< 2) + outer_w) + AW'(WIENER_ROUND);
			end
			K_BICUBIC: begin
				sum = (inner_b <<< 3) + inner_b - outer_b + AW'(BICUBIC_ROUND);
			end
			K_AVG: begin
				sum = pair_a + AW'(1);
			end
			default: begin
				sum = x[0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s2 <= sum;
			ctl_s2 <= ctl;
		end
	end
endmodule

// ----- hw/rtl/half_sample_line_interpolator_unit.sv -----
// top level of the half-sample line interpolator
//
//  channel | handshake          | payload
//  --------+--------------------+---------------------------
//  in      | in_valid/in_ready  | sample_in, line_end
//  out     | out_valid/out_ready| half_sample, line_done
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// one sample per cycle while the output is not stalled; a sample with line_end stalls the input
// while the sequencer emits one position per cycle from the tap cells, unless the kernel stage is held
// a result passes from the sequencer through the kernel and output registers to out_valid
// reset clears the window, line position and pipeline valids and loads the configuration defaults
// output stalls back up through the clamp and kernel stages to in_ready
module half_sample_line_interpolator_unit #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] sample_in,
	input  logic        line_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] half_sample,
	output logic        line_done
);
	import hsli_pkg::*;

	localparam int AW = SAMPLE_WIDTH + 7;

	logic [1:0]  filter_mode_q;
	logic [4:0]  sample_bits_q;
	logic [3:0]  pos_q;

	logic [TAPS-1:0][SAMPLE_WIDTH-1:0] taps;

	logic        s1_valid_q;
	logic [3:0]  n_s1;
	logic        last_s1;
	logic [1:0]  d_s1;

	logic        s2_valid_q;
	logic signed [AW-1:0] acc_s2;
	sel_t        ctl_s2;

	logic        out_valid_q;
	logic [15:0] half_sample_q;
	logic        line_done_q;

	logic        out_free;
	logic        s2_free;
	logic        s2_adv;
	logic        emit;
	logic        s1_fin;
	logic        accept;
	logic        has_res;
	logic        is_wiener;
	sel_t        sel;

	logic [4:0]             bits_eff;
	logic [SAMPLE_WIDTH-1:0] mx;
	logic signed [AW-1:0]   shifted;
	logic [SAMPLE_WIDTH-1:0] res;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= FILTER_MODE_RST;
			sample_bits_q <= SAMPLE_BITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FILTER_MODE: filter_mode_q <= cfg_data[1:0];
				REG_SAMPLE_BITS: sample_bits_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake and stage advance
	assign out_free = !out_valid_q || out_ready;
	assign s2_adv   = s2_valid_q && out_free;
	assign s2_free  = !s2_valid_q || out_free;
	assign emit     = s1_valid_q && s2_free;
	assign s1_fin   = emit && (!last_s1 || d_s1 == 2'd0);
	assign in_ready = !s1_valid_q || s1_fin;
	assign accept   = in_valid && in_ready;
	assign has_res  = line_end || (pos_q >= LAG);

	// sample window
	for (genvar i = 0; i < TAPS; i++) begin : g_cell
		if (i == 0) begin : g_head
			hsli_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (accept),
				.d        (sample_in[SAMPLE_WIDTH-1:0]),
				.q        (taps[i])
			);
		end else begin : g_link
			hsli_tap_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (accept),
				.d        (taps[i-1]),
				.q        (taps[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				pos_q <= '0;
			end else if (pos_q < POS_SAT) begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// position sequencer: once accepted, the cells hold samples n..n-5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= has_res;
		end else if (s1_fin) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_s1    <= pos_q;
			last_s1 <= line_end;
			d_s1    <= (line_end && pos_q < LAG) ? pos_q[1:0] : 2'd3;
		end else if (emit && !s1_fin) begin
			d_s1 <= d_s1 - 2'd1;
		end
	end

	assign is_wiener = filter_mode_q == MODE_WIENER || filter_mode_q == MODE_RESERVED;

	always_comb begin
		sel.dsel = d_s1;
		sel.done = last_s1 && d_s1 == 2'd0;
		if (d_s1 == 2'd0) begin
			sel.kern = K_COPY;
		end else if (!last_s1 && is_wiener && n_s1 >= WIENER_MIN_N) begin
			sel.kern = K_WIENER;
		end else if (d_s1 == 2'd3 && filter_mode_q == MODE_BICUBIC
			&& n_s1 >= BICUBIC_MIN_N) begin
			sel.kern = K_BICUBIC;
		end else begin
			sel.kern = K_AVG;
		end
	end

	hsli_kernel #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_kernel (
		.clk    (clk),
		.en     (emit),
		.taps   (taps),
		.ctl    (sel),
		.acc_s2 (acc_s2),
		.ctl_s2 (ctl_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (emit) begin
			s2_valid_q <= 1'b1;
		end else if (s2_adv) begin
			s2_valid_q <= 1'b0;
		end
	end

	// clamp limit from sample_bits, held to 8..SAMPLE_WIDTH
	always_comb begin
		if (sample_bits_q < MIN_SAMPLE_BITS) begin
			bits_eff = MIN_SAMPLE_BITS;
		end else if (sample_bits_q > 5'(SAMPLE_WIDTH)) begin
			bits_eff = 5'(SAMPLE_WIDTH);
		end else begin
			bits_eff = sample_bits_q;
		end
		mx = SAMPLE_WIDTH'((AW'(1) << bits_eff) - AW'(1));
	end

	always_comb begin
		case (ctl_s2.kern)
			K_WIENER:  shifted = acc_s2 >>> WIENER_SHIFT;
			K_BICUBIC: shifted = acc_s2 >>> BICUBIC_SHIFT;
			K_AVG:     shifted = acc_s2 >>> 1;
			default:   shifted = acc_s2;
		endcase
		res = shifted[SAMPLE_WIDTH-1:0];
		// only filter sums are clamped
		if (ctl_s2.kern == K_WIENER || ctl_s2.kern == K_BICUBIC) begin
			if (acc_s2 < 0) begin
				res = '0;
			end else if (shifted > $signed(AW'(mx))) begin
				res = mx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			half_sample_q <= 16'(res);
			line_done_q   <= ctl_s2.done;
		end
	end

	assign out_valid   = out_valid_q;
	assign half_sample = half_sample_q;
	assign line_done   = line_done_q;

	// non-final requests always emit exactly the position three behind
	a_single_pos: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !last_s1 |-> d_s1 == 2'd3)
		else $error("sequencer lost its position for a mid-line request");

	// six-tap sum only once all six taps are in the line
	a_wiener_taps: assert property (@(posedge clk) disable iff (!arst_n)
		emit && sel.kern == K_WIENER |-> n_s1 >= WIENER_MIN_N && !last_s1)
		else $error("six-tap filter picked with taps outside the line");

	// a line end restarts the position count
	a_line_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && line_end |=> pos_q == 4'd0 && s1_valid_q)
		else $error("line end did not restart the line");
endmodule
